FILE: design/hcm_pkg.sv
package hcm_pkg;

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        ACT_SCAN  = 2'd0,
        ACT_COLOR = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // quotient bits: t <= 1020 and q <= 304 both fit
    localparam int QUO_W = 11;
    localparam int CNT_W = 4;

    localparam logic [7:0] SEG0_BASE = 8'd76;
    localparam logic [7:0] CH_MAX    = 8'd255;
    localparam logic [7:0] CH_OFFSET = 8'd64;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAMP,
        S_SEG,
        S_DIV,
        S_MAP
    } t_state;

    // gradient segment, lowest first
    typedef enum logic [1:0] {
        SEG_VB,
        SEG_BG,
        SEG_GR,
        SEG_RY
    } t_seg;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } t_div_stat;

    // c*3/4 + 64
    function automatic logic [7:0] compress(input logic [7:0] c);
        logic [9:0] tmp;
        tmp = {2'b00, c} + {1'b0, c, 1'b0};
        return tmp[9:2] + CH_OFFSET;
    endfunction

endpackage

FILE: design/hcm_div.sv
module hcm_div #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [SAMPLE_WIDTH+9:0]       i_numer,
    input  logic [SAMPLE_WIDTH-1:0]       i_denom,
    output hcm_pkg::t_div_stat            o_stat
);
    import hcm_pkg::*;

    localparam int NW = SAMPLE_WIDTH + 10;

    logic [SAMPLE_WIDTH:0]   r_rem;
    logic [QUO_W-1:0]        r_num_lo;
    logic [QUO_W-1:0]        r_quo;
    logic [SAMPLE_WIDTH-1:0] r_den;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_busy;
    logic                    r_done;

    logic [SAMPLE_WIDTH:0]   rem_sh;
    logic [SAMPLE_WIDTH:0]   rem_sub;
    logic                    fits;

    // restoring step: shift one numerator bit in, try the subtract
    always_comb begin
        rem_sh  = {r_rem[SAMPLE_WIDTH-1:0], r_num_lo[QUO_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        fits    = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QUO_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // quotient < 2^QUO_W, so the upper numerator bits are already < divisor
            r_rem    <= {2'b00, i_numer[NW-1:QUO_W]};
            r_num_lo <= i_numer[QUO_W-1:0];
            r_den    <= i_denom;
            r_quo    <= '0;
        end else if (r_busy) begin
            r_rem    <= fits ? rem_sub : rem_sh;
            r_num_lo <= {r_num_lo[QUO_W-2:0], 1'b0};
            r_quo    <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.quotient = r_quo;

endmodule

FILE: design/heatmap_color_mapper_top.sv
// Scan and clear requests: no result, the input stays ready.
// Colour requests pass clamp, segment compare, an 11-step restoring divider and map
// before the result is loaded, and no new request is taken until then; a zero range
// skips the divider. A full, stalled result register adds its stall. Input is not
// ready while a colour request is in work.
// Reset (i_rst_n low, synchronous) empties the range and drops any pending result.
module heatmap_color_mapper_top #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // input request
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // [SW-1:0] sample, rest zero
    input  logic [1:0]                             s_axis_tuser,  // [1:0] action
    // colour result
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [23:0]                            m_axis_tdata   // {blue, green, red}, red in bits [7:0]
);
    import hcm_pkg::*;

    localparam int SW = SAMPLE_WIDTH;
    localparam int NW = SAMPLE_WIDTH + 10;

    // running range
    logic signed [SW-1:0] r_low, r_high;
    logic                 r_seen;

    // colour request working registers
    logic signed [SW-1:0] r_v;
    logic [SW-1:0]        r_d;       // clamped sample minus low bound
    logic [SW-1:0]        r_r;       // range width
    t_seg                 r_seg;
    logic [QUO_W-1:0]     r_t;       // t, or q for the lowest segment

    // result register
    logic                 r_out_valid;
    logic [7:0]           r_red, r_green, r_blue;

    t_state               r_state, n_state;

    logic                 in_acc;
    logic                 out_load;
    logic signed [SW-1:0] smp;
    logic signed [SW-1:0] v_cl;
    logic [SW+1:0]        d4, r1, r2, r3;
    logic [NW-1:0]        numer;
    logic                 div_start;
    t_div_stat            div_stat;
    logic [QUO_W-1:0]     k_sub;
    logic [7:0]           k;
    logic [QUO_W-1:0]     ch_tmp;
    logic [7:0]           cr, cg, cb;

    assign smp           = s_axis_tdata[SW-1:0];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_MAP) && (!r_out_valid || m_axis_tready);

    // clamp to [low, high]
    always_comb begin
        if (r_v < r_low) begin
            v_cl = r_low;
        end else if (r_v > r_high) begin
            v_cl = r_high;
        end else begin
            v_cl = r_v;
        end
    end

    // segment compares: 4d against R, 2R, 3R
    always_comb begin
        d4 = {r_d, 2'b00};
        r1 = {2'b00, r_r};
        r2 = {1'b0, r_r, 1'b0};
        r3 = r1 + r2;
    end

    // numerator: d*1020 for t, d*304 for the lowest segment
    always_comb begin
        if (d4 > r1) begin
            numer = {r_d, 10'b0} - {8'b0, r_d, 2'b00};
        end else begin
            numer = {2'b00, r_d, 8'b0} + {5'b0, r_d, 5'b0} + {6'b0, r_d, 4'b0};
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && t_action'(s_axis_tuser) == ACT_COLOR) begin
                    n_state = S_CLAMP;
                end
            end
            S_CLAMP: begin
                n_state = S_SEG;
            end
            S_SEG: begin
                if (r_r == '0) begin
                    n_state = S_MAP;  // zero range: lowest segment, quotient 0
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // range tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
            r_seen <= 1'b0;
        end else if (in_acc) begin
            case (t_action'(s_axis_tuser))
                ACT_SCAN: begin
                    r_seen <= 1'b1;
                    if (!r_seen) begin
                        r_low  <= smp;
                        r_high <= smp;
                    end else begin
                        if (smp < r_low)  r_low  <= smp;
                        if (smp > r_high) r_high <= smp;
                    end
                end
                ACT_CLEAR: begin
                    r_low  <= '0;
                    r_high <= '0;
                    r_seen <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // colour datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_v <= smp;
        end
        if (r_state == S_CLAMP) begin
            r_d <= SW'(v_cl - r_low);
            r_r <= SW'(r_high - r_low);
        end
        if (r_state == S_SEG) begin
            if (r_r == '0) begin
                r_seg <= SEG_VB;
                r_t   <= '0;
            end else if (d4 > r3) begin
                r_seg <= SEG_RY;
            end else if (d4 > r2) begin
                r_seg <= SEG_GR;
            end else if (d4 > r1) begin
                r_seg <= SEG_BG;
            end else begin
                r_seg <= SEG_VB;
            end
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_t <= div_stat.quotient;
        end
    end

    hcm_div #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (numer),
        .i_denom (r_r),
        .o_stat  (div_stat)
    );

    // raw channels per segment
    always_comb begin
        k_sub  = QUO_W'(SEG0_BASE) - r_t;
        k      = (r_t <= QUO_W'(SEG0_BASE)) ? k_sub[7:0] : 8'd0;
        ch_tmp = '0;
        cr     = '0;
        cg     = '0;
        cb     = '0;
        case (r_seg)
            SEG_RY: begin
                ch_tmp = QUO_W'(1020) - r_t;
                cr     = CH_MAX;
                cg     = ch_tmp[7:0];
            end
            SEG_GR: begin
                ch_tmp = r_t - QUO_W'(510);
                cr     = ch_tmp[7:0];
                cg     = CH_MAX;
            end
            SEG_BG: begin
                ch_tmp = r_t - QUO_W'(255);
                cg     = ch_tmp[7:0];
                cb     = CH_MAX - ch_tmp[7:0];
            end
            default: begin
                cr = k;
                cb = CH_MAX - k;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_red   <= compress(cr);
            r_green <= compress(cg);
            r_blue  <= compress(cb);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_blue, r_green, r_red};

endmodule

FILE: design/hcm_chk.sv
module hcm_chk #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    input logic [1:0]                             s_axis_tuser,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [23:0]                            m_axis_tdata
);
    import hcm_pkg::*;

    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // every channel is compressed into 64..255
    a_chan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:6] != 2'b00) && (m_axis_tdata[15:14] != 2'b00)
                          && (m_axis_tdata[23:22] != 2'b00))
        else $error("channel below offset");

    // one raw channel is always zero in every segment
    a_one_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] == CH_OFFSET) || (m_axis_tdata[15:8] == CH_OFFSET)
                          || (m_axis_tdata[23:16] == CH_OFFSET))
        else $error("no dark channel");

    // colour request blocks the input, scan and clear do not
    a_color_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser == ACT_COLOR |=> !s_axis_tready)
        else $error("ready during colour work");

    a_noncolor_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && s_axis_tuser != ACT_COLOR |=> s_axis_tready && !$rose(m_axis_tvalid))
        else $error("scan or clear produced a result");

endmodule

bind heatmap_color_mapper_top hcm_chk #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_hcm_chk (.*);
